// ===== rtl/lwd_pkg.sv =====
// ----------------------------------------------------------------------------
// lwd_pkg
// Shared types and constants for the LZSS window decompressor.
// ----------------------------------------------------------------------------
package lwd_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 5;

    localparam logic [BYTE_W-1:0] FILL_BYTE     = 8'h20;
    localparam logic [3:0]        FLAG_COUNT    = 4'd8;
    localparam logic [CNT_W-1:0]  COPY_CNT_BIAS = 5'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } ctrl_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } out_word_t;

endpackage

// ===== rtl/lwd_history.sv =====
// ----------------------------------------------------------------------------
// lwd_history
// History window memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lwd_history #(
    parameter int WINDOW_BITS = 12
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [WINDOW_BITS-1:0]   waddr,
    input  logic [lwd_pkg::BYTE_W-1:0] wdata,
    input  logic                     re,
    input  logic [WINDOW_BITS-1:0]   raddr,
    output logic [lwd_pkg::BYTE_W-1:0] rdata
);
    import lwd_pkg::*;

    localparam int DEPTH = 1 << WINDOW_BITS;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lwd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lwd_ctrl
// Token parser and copy sequencer: decodes flag, literal and reference bytes
// and steps the shared source-address unit through each copy.
// ----------------------------------------------------------------------------
module lwd_ctrl #(
    parameter int WINDOW_BITS = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [lwd_pkg::BYTE_W-1:0] in_byte,
    input  logic                       out_free,
    output logic                       out_load,
    output lwd_pkg::out_word_t         out_word,
    output logic                       mem_we,
    output logic [WINDOW_BITS-1:0]     mem_waddr,
    output logic [lwd_pkg::BYTE_W-1:0] mem_wdata,
    output logic                       mem_re,
    output logic [WINDOW_BITS-1:0]     mem_raddr,
    input  logic [lwd_pkg::BYTE_W-1:0] mem_rdata
);
    import lwd_pkg::*;

    ctrl_state_t             state_reg, state_next;
    logic [WINDOW_BITS-1:0]  wp_reg, wp_next;
    logic                    wrapped_reg, wrapped_next;
    logic [BYTE_W-1:0]       flag_bits_reg, flag_bits_next;
    logic [3:0]              flags_left_reg, flags_left_next;
    logic [BYTE_W-1:0]       ref_low_reg, ref_low_next;
    logic                    ref_half_reg, ref_half_next;
    logic [WINDOW_BITS-1:0]  off_reg, off_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    hit_reg, hit_next;

    logic                    accept;
    logic [WINDOW_BITS-1:0]  src_addr;
    logic [BYTE_W-1:0]       copy_byte;

    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign src_addr  = wp_reg - off_reg;
    assign copy_byte = hit_reg ? mem_rdata : FILL_BYTE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            wrapped_reg    <= 1'b0;
            flag_bits_reg  <= '0;
            flags_left_reg <= '0;
            ref_low_reg    <= '0;
            ref_half_reg   <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            wrapped_reg    <= wrapped_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            ref_low_reg    <= ref_low_next;
            ref_half_reg   <= ref_half_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_reg <= off_next;
        hit_reg <= hit_next;
    end

    always_comb begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        wrapped_next    = wrapped_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        ref_low_next    = ref_low_reg;
        ref_half_next   = ref_half_reg;
        off_next        = off_reg;
        cnt_next        = cnt_reg;
        hit_next        = hit_reg;
        out_load        = 1'b0;
        out_word.data   = in_byte;
        out_word.last   = 1'b1;
        mem_we          = 1'b0;
        mem_waddr       = wp_reg;
        mem_wdata       = in_byte;
        mem_re          = 1'b0;
        mem_raddr       = src_addr;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (flags_left_reg == '0) begin
                        flag_bits_next  = in_byte;
                        flags_left_next = FLAG_COUNT;
                    end else if (flag_bits_reg[0]) begin
                        mem_we          = 1'b1;
                        out_load        = 1'b1;
                        wp_next         = wp_reg + 1'b1;
                        wrapped_next    = wrapped_reg || (wp_reg == '1);
                        flag_bits_next  = flag_bits_reg >> 1;
                        flags_left_next = flags_left_reg - 1'b1;
                    end else if (!ref_half_reg) begin
                        ref_low_next  = in_byte;
                        ref_half_next = 1'b1;
                    end else begin
                        off_next        = WINDOW_BITS'({in_byte[7:4], ref_low_reg});
                        cnt_next        = CNT_W'(in_byte[3:0]) + COPY_CNT_BIAS;
                        ref_low_next    = '0;
                        ref_half_next   = 1'b0;
                        flag_bits_next  = flag_bits_reg >> 1;
                        flags_left_next = flags_left_reg - 1'b1;
                        state_next      = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // unwritten positions read as fill
                mem_re     = 1'b1;
                hit_next   = wrapped_reg || (src_addr < wp_reg);
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                out_word.data = copy_byte;
                out_word.last = (cnt_reg == '0);
                mem_wdata     = copy_byte;
                if (out_free) begin
                    mem_we       = 1'b1;
                    out_load     = 1'b1;
                    wp_next      = wp_reg + 1'b1;
                    wrapped_next = wrapped_reg || (wp_reg == '1);
                    if (cnt_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded into a busy output register");

    a_read_then_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> (state_reg == ST_WRITE))
        else $error("copy read not followed by write");

    a_last_ends_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_word.last && (state_reg == ST_WRITE)) |=> (state_reg == ST_IDLE))
        else $error("copy did not end after its last byte");

    a_wrapped_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        wrapped_reg |=> wrapped_reg)
        else $error("window fill mark cleared outside reset");

endmodule

// ===== rtl/lzss_window_decompressor_core.sv =====
// ----------------------------------------------------------------------------
// lzss_window_decompressor_core
// LZSS decompressor over a history window, one compressed byte per word.
// ----------------------------------------------------------------------------
// Flag, literal and first reference bytes are each taken while idle with a
// free output register; a literal word is emitted at once. The second
// reference byte starts a copy of 3 to 18 bytes, each by a registered read of
// the single window memory, then write-back and emit once the output register
// is free; no word is accepted until the copy ends. The window needs no
// clearing pass: a fill mark tracks which positions were written and the rest
// read as 0x20. m_tlast marks the final output word caused by an input word.
module lzss_window_decompressor_core #(
    parameter int WINDOW_BITS = 12
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast    // run_last
);
    import lwd_pkg::*;

    logic                   out_valid_reg;
    out_word_t              out_word_reg;
    logic                   out_free;
    logic                   out_load;
    out_word_t              out_word;
    logic                   mem_we;
    logic [WINDOW_BITS-1:0] mem_waddr;
    logic [BYTE_W-1:0]      mem_wdata;
    logic                   mem_re;
    logic [WINDOW_BITS-1:0] mem_raddr;
    logic [BYTE_W-1:0]      mem_rdata;

    assign out_free = !out_valid_reg || m_tready;

    lwd_ctrl #(
        .WINDOW_BITS(WINDOW_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .out_free  (out_free),
        .out_load  (out_load),
        .out_word  (out_word),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    lwd_history #(
        .WINDOW_BITS(WINDOW_BITS)
    ) u_history (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= out_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_word_reg <= out_word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg.data;
    assign m_tlast  = out_word_reg.last;

endmodule

// ===== verif/lwd_stream_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lwd_stream_checker
// Watches both stream channels of the LZSS window decompressor. Every
// accepted compressed word is decoded against a private copy of the history
// window. The decoded bytes are queued in order, and each output word is
// compared with the oldest queued byte and its end-of-run mark.
// ----------------------------------------------------------------------------
module lwd_stream_checker #(
    parameter int WINDOW_BITS = 12
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // out_byte
    input  logic       m_tlast,   // run_last
    output int         mismatch_count,
    output int         bytes_outstanding
);
    import lwd_pkg::*;

    localparam int WIN_DEPTH = 1 << WINDOW_BITS;

    logic [BYTE_W-1:0]      window_mem [WIN_DEPTH];
    logic [WINDOW_BITS-1:0] wr_ptr;
    logic [7:0]             ctrl_bits;
    logic [3:0]             ctrl_left;
    logic [7:0]             ref_lo;
    logic                   ref_pending;
    out_word_t              decoded_q [$];

    task automatic decode_byte(input logic [7:0] b);
        logic [WINDOW_BITS-1:0] ref_off;
        logic [WINDOW_BITS-1:0] dst;
        int                     run_len;
        int                     i;
        out_word_t              w;
        if (ctrl_left == '0) begin
            ctrl_bits = b;
            ctrl_left = FLAG_COUNT;
        end else if (ctrl_bits[0]) begin
            window_mem[wr_ptr] = b;
            wr_ptr = wr_ptr + 1'b1;
            w.data = b;
            w.last = 1'b1;
            decoded_q.push_back(w);
            ctrl_bits = ctrl_bits >> 1;
            ctrl_left = ctrl_left - 1'b1;
        end else if (!ref_pending) begin
            ref_lo      = b;
            ref_pending = 1'b1;
        end else begin
            ref_off = WINDOW_BITS'({b[7:4], ref_lo});
            run_len = int'(b[3:0]) + 3;
            for (i = 0; i < run_len; i++) begin
                dst = wr_ptr + WINDOW_BITS'(i);
                // zero offset replays what already sits in the window
                if (ref_off != '0) begin
                    window_mem[dst] = window_mem[dst - ref_off];
                end
                w.data = window_mem[dst];
                w.last = (i == run_len - 1);
                decoded_q.push_back(w);
            end
            wr_ptr      = wr_ptr + WINDOW_BITS'(run_len);
            ref_pending = 1'b0;
            ref_lo      = '0;
            ctrl_bits   = ctrl_bits >> 1;
            ctrl_left   = ctrl_left - 1'b1;
        end
    endtask

    always @(posedge aclk) begin : monitor_proc
        out_word_t want;
        if (!aresetn) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                window_mem[i] = FILL_BYTE;
            end
            wr_ptr         = '0;
            ctrl_bits      = '0;
            ctrl_left      = '0;
            ref_lo         = '0;
            ref_pending    = 1'b0;
            mismatch_count = 0;
            decoded_q.delete();
        end else begin
            // decode first so every byte is queued before it can leave
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected output word data %02h last %0b",
                                 $realtime, m_tdata, m_tlast);
                    end
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"%0t: output mismatch, expected data %02h last %0b,",
                                      " got data %02h last %0b"},
                                     $realtime, want.data, want.last, m_tdata, m_tlast);
                        end
                    end
                end
            end
        end
        bytes_outstanding = decoded_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the LZSS window decompressor. A directed
// compressed stream covering literal extremes, zero-distance, overlapping and
// full-window references is followed by random flag groups that mix zero, short
// and full-range distances. The sender works in bursts and the receiver stalls in shifting
// patterns; checking is left to the stream checker.
// ----------------------------------------------------------------------------
module tb_top;
    import lwd_pkg::*;

    localparam int WINDOW_BITS  = 12;
    localparam int RANDOM_ITEMS = 310;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400000;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int         mismatch_count;
    int         bytes_outstanding;
    int         cycle_cnt = 0;
    int         stall_mode = 0;
    int         mode_left = 0;
    logic [1:0] stall_phase = '0;

    logic [7:0] stream_q [$];

    always #1 aclk = ~aclk;

    lzss_window_decompressor_core #(
        .WINDOW_BITS(WINDOW_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    lwd_stream_checker #(
        .WINDOW_BITS(WINDOW_BITS)
    ) u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding)
    );

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready    <= 1'b0;
            stall_mode  <= 0;
            mode_left   <= 0;
            stall_phase <= '0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(16, 96);
            end else begin
                mode_left <= mode_left - 1;
            end
            stall_phase <= stall_phase + 1'b1;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= stall_phase[1];
            endcase
        end
    end

    task automatic build_stream();
        logic [7:0]  flag;
        logic [11:0] ref_off;
        logic [3:0]  nib;
        int          k;
        // flag 0x0F: four literals, then zero distance, overlap by one
        // at full length, full window span, short copy
        stream_q = '{8'h0F, 8'h00, 8'hFF, 8'h41, 8'h5A,
                     8'h00, 8'h00, 8'h01, 8'h0F, 8'hFF, 8'hFF, 8'h04, 8'h00,
                     8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h20, 8'h33};
        while (stream_q.size() < 22 + RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0: flag = 8'hFF;
                1: flag = 8'h00;
                default: flag = 8'($urandom);
            endcase
            stream_q.push_back(flag);
            for (k = 0; k < 8; k++) begin
                if (flag[k]) begin
                    stream_q.push_back(8'($urandom_range(0, 255)));
                end else begin
                    case ($urandom_range(0, 7))
                        0: ref_off = '0;
                        1, 2, 3: ref_off = 12'($urandom_range(1, 16));
                        default: ref_off = 12'($urandom_range(0, 4095));
                    endcase
                    nib = 4'($urandom_range(0, 15));
                    stream_q.push_back(ref_off[7:0]);
                    stream_q.push_back({ref_off[11:8], nib});
                end
            end
        end
    endtask

    task automatic send_stream();
        int idx;
        int burst;
        int gap;
        int k;
        idx = 0;
        while (idx < stream_q.size()) begin
            burst = $urandom_range(1, 40);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            for (k = 0; k < burst && idx < stream_q.size(); k++) begin
                s_tvalid <= 1'b1;
                s_tdata  <= stream_q[idx];
                do @(posedge aclk); while (!s_tready);
                idx++;
            end
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        build_stream();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_stream();
        @(negedge aclk);
        while (bytes_outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && bytes_outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
